### sv/md5de_pkg.sv
`default_nettype none

package md5de_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } state_t;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [31:0] PAD_MARK = 32'h00000080;
    localparam logic [3:0]  LAST_POS = 4'd15;
    localparam logic [3:0]  LEN_POS  = 4'd14;
    localparam logic [5:0]  LAST_RND = 6'd63;

    // Message word index used by each round
    function automatic logic [3:0] msg_index(input logic [5:0] rnd);
        logic [3:0] j;
        logic [3:0] g;
        begin
            j = rnd[3:0];
            case (rnd[5:4])
                2'd0:    g = j;
                2'd1:    g = 4'((j << 2) + j + 4'd1);
                2'd2:    g = 4'((j << 1) + j + 4'd5);
                default: g = 4'((j << 3) - j);
            endcase
            return g;
        end
    endfunction

    function automatic logic [4:0] rot_amount(input logic [5:0] rnd);
        logic [4:0] s;
        begin
            case ({rnd[5:4], rnd[1:0]})
                4'h0:    s = 5'd7;
                4'h1:    s = 5'd12;
                4'h2:    s = 5'd17;
                4'h3:    s = 5'd22;
                4'h4:    s = 5'd5;
                4'h5:    s = 5'd9;
                4'h6:    s = 5'd14;
                4'h7:    s = 5'd20;
                4'h8:    s = 5'd4;
                4'h9:    s = 5'd11;
                4'ha:    s = 5'd16;
                4'hb:    s = 5'd23;
                4'hc:    s = 5'd6;
                4'hd:    s = 5'd10;
                4'he:    s = 5'd15;
                default: s = 5'd21;
            endcase
            return s;
        end
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
        logic [63:0] t;
        begin
            t = {x, x} << s;
            return t[63:32];
        end
    endfunction

    function automatic logic [31:0] round_const(input logic [5:0] rnd);
        logic [31:0] k;
        begin
            case (rnd)
                6'd0:  k = 32'hd76aa478;
                6'd1:  k = 32'he8c7b756;
                6'd2:  k = 32'h242070db;
                6'd3:  k = 32'hc1bdceee;
                6'd4:  k = 32'hf57c0faf;
                6'd5:  k = 32'h4787c62a;
                6'd6:  k = 32'ha8304613;
                6'd7:  k = 32'hfd469501;
                6'd8:  k = 32'h698098d8;
                6'd9:  k = 32'h8b44f7af;
                6'd10: k = 32'hffff5bb1;
                6'd11: k = 32'h895cd7be;
                6'd12: k = 32'h6b901122;
                6'd13: k = 32'hfd987193;
                6'd14: k = 32'ha679438e;
                6'd15: k = 32'h49b40821;
                6'd16: k = 32'hf61e2562;
                6'd17: k = 32'hc040b340;
                6'd18: k = 32'h265e5a51;
                6'd19: k = 32'he9b6c7aa;
                6'd20: k = 32'hd62f105d;
                6'd21: k = 32'h02441453;
                6'd22: k = 32'hd8a1e681;
                6'd23: k = 32'he7d3fbc8;
                6'd24: k = 32'h21e1cde6;
                6'd25: k = 32'hc33707d6;
                6'd26: k = 32'hf4d50d87;
                6'd27: k = 32'h455a14ed;
                6'd28: k = 32'ha9e3e905;
                6'd29: k = 32'hfcefa3f8;
                6'd30: k = 32'h676f02d9;
                6'd31: k = 32'h8d2a4c8a;
                6'd32: k = 32'hfffa3942;
                6'd33: k = 32'h8771f681;
                6'd34: k = 32'h6d9d6122;
                6'd35: k = 32'hfde5380c;
                6'd36: k = 32'ha4beea44;
                6'd37: k = 32'h4bdecfa9;
                6'd38: k = 32'hf6bb4b60;
                6'd39: k = 32'hbebfbc70;
                6'd40: k = 32'h289b7ec6;
                6'd41: k = 32'heaa127fa;
                6'd42: k = 32'hd4ef3085;
                6'd43: k = 32'h04881d05;
                6'd44: k = 32'hd9d4d039;
                6'd45: k = 32'he6db99e5;
                6'd46: k = 32'h1fa27cf8;
                6'd47: k = 32'hc4ac5665;
                6'd48: k = 32'hf4292244;
                6'd49: k = 32'h432aff97;
                6'd50: k = 32'hab9423a7;
                6'd51: k = 32'hfc93a039;
                6'd52: k = 32'h655b59c3;
                6'd53: k = 32'h8f0ccc92;
                6'd54: k = 32'hffeff47d;
                6'd55: k = 32'h85845dd1;
                6'd56: k = 32'h6fa87e4f;
                6'd57: k = 32'hfe2ce6e0;
                6'd58: k = 32'ha3014314;
                6'd59: k = 32'h4e0811a1;
                6'd60: k = 32'hf7537e82;
                6'd61: k = 32'hbd3af235;
                6'd62: k = 32'h2ad7d2bb;
                default: k = 32'heb86d391;
            endcase
            return k;
        end
    endfunction

endpackage

`default_nettype wire

### sv/md5_digest_engine_unit.sv
`default_nettype none
// A plain word is only written to the block buffer; the sixteenth word of a block starts
// 64 rounds, one per cycle through the single round unit, followed by the chaining add.
// Words are taken only while idle; busy stays high while a block is compressed.
// Last word: padding is written one word a cycle, with one or two more compressions;
// the digest appears for one cycle on done, which the receiver cannot stall.
// Reset: chaining words return to the MD5 initial values; the block buffer is not cleared.

module md5_digest_engine_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] data_word,
    input  wire logic [2:0]  byte_count,
    input  wire logic        last_word,
    output logic             done,
    output logic [31:0]      digest_a,
    output logic [31:0]      digest_b,
    output logic [31:0]      digest_c,
    output logic [31:0]      digest_d
);

    md5de_pkg::state_t state_reg, state_next;

    // Block buffer: one synchronous memory, one write and one registered read a cycle
    logic [31:0] buf_mem [16];
    logic [31:0] rdata_reg;
    logic        mem_we;
    logic [31:0] mem_wdata;
    logic [3:0]  mem_raddr;

    logic [3:0]  pos_reg, pos_next;
    logic [60:0] bytes_reg, bytes_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic        need80_reg, need80_next;   // full last word: marker still to write
    logic        final_reg, final_next;     // message is being closed
    logic        lenlo_reg, lenlo_next;     // low length word written
    logic        lendone_reg, lendone_next; // high length word written
    logic [31:0] chain_reg [4];
    logic [31:0] chain_next [4];
    logic [31:0] work_reg [4];
    logic [31:0] work_next [4];

    logic        accept;
    logic        wrap;
    logic [63:0] bit_len;
    logic [31:0] keep_mask;
    logic [31:0] mark_word;
    logic [2:0]  cnt_clamped;
    logic [31:0] f_val;
    logic [31:0] sum_val;
    logic [31:0] b_new;

    assign busy     = (state_reg != md5de_pkg::ST_IDLE);
    assign accept   = start && !busy;
    assign wrap     = mem_we && (pos_reg == md5de_pkg::LAST_POS);
    assign bit_len  = {bytes_reg, 3'b000};
    assign done     = (state_reg == md5de_pkg::ST_OUT);
    assign digest_a = chain_reg[0];
    assign digest_b = chain_reg[1];
    assign digest_c = chain_reg[2];
    assign digest_d = chain_reg[3];

    // Byte counts above four count as a full word
    assign cnt_clamped = byte_count[2] ? 3'd4 : byte_count;

    // Short last word: clear the unused bytes and drop the marker right above the kept ones
    always_comb
    begin
        case (byte_count[1:0])
            2'd0:    keep_mask = 32'h00000000;
            2'd1:    keep_mask = 32'h000000ff;
            2'd2:    keep_mask = 32'h0000ffff;
            default: keep_mask = 32'h00ffffff;
        endcase
        mark_word = (data_word & keep_mask)
                  | (md5de_pkg::PAD_MARK << {byte_count[1:0], 3'b000});
    end

    // One MD5 step on the working words; rdata_reg holds this round's message word
    always_comb
    begin
        case (rnd_reg[5:4])
            2'd0:    f_val = (work_reg[1] & work_reg[2]) | (~work_reg[1] & work_reg[3]);
            2'd1:    f_val = (work_reg[1] & work_reg[3]) | (work_reg[2] & ~work_reg[3]);
            2'd2:    f_val = work_reg[1] ^ work_reg[2] ^ work_reg[3];
            default: f_val = work_reg[2] ^ (work_reg[1] | ~work_reg[3]);
        endcase
        sum_val = work_reg[0] + f_val + md5de_pkg::round_const(rnd_reg) + rdata_reg;
        b_new   = work_reg[1]
                + md5de_pkg::rotl32(sum_val, md5de_pkg::rot_amount(rnd_reg));
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            md5de_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (wrap)
                        state_next = md5de_pkg::ST_ROUND;
                    else if (last_word)
                        state_next = md5de_pkg::ST_PAD;
                end
            end
            md5de_pkg::ST_PAD:
            begin
                if (wrap)
                    state_next = md5de_pkg::ST_ROUND;
            end
            md5de_pkg::ST_ROUND:
            begin
                if (rnd_reg == md5de_pkg::LAST_RND)
                    state_next = md5de_pkg::ST_ADD;
            end
            md5de_pkg::ST_ADD:
            begin
                if (!final_reg)
                    state_next = md5de_pkg::ST_IDLE;
                else if (lendone_reg)
                    state_next = md5de_pkg::ST_OUT;
                else
                    state_next = md5de_pkg::ST_PAD;
            end
            md5de_pkg::ST_OUT:
                state_next = md5de_pkg::ST_IDLE;
            default:
                state_next = md5de_pkg::ST_IDLE;
        endcase
    end

    // Datapath control and register next values
    always_comb
    begin
        mem_we       = 1'b0;
        mem_wdata    = data_word;
        // Outside the rounds, prefetch word 0 for the first round
        mem_raddr    = 4'd0;
        pos_next     = pos_reg;
        bytes_next   = bytes_reg;
        rnd_next     = rnd_reg;
        need80_next  = need80_reg;
        final_next   = final_reg;
        lenlo_next   = lenlo_reg;
        lendone_next = lendone_reg;
        for (int i = 0; i < 4; i++)
        begin
            chain_next[i] = chain_reg[i];
            work_next[i]  = work_reg[i];
        end

        case (state_reg)
            md5de_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    mem_we = 1'b1;
                    if (!last_word)
                    begin
                        mem_wdata  = data_word;
                        bytes_next = bytes_reg + 61'd4;
                    end
                    else
                    begin
                        final_next = 1'b1;
                        bytes_next = bytes_reg + 61'(cnt_clamped);
                        if (cnt_clamped == 3'd4)
                        begin
                            mem_wdata   = data_word;
                            need80_next = 1'b1;
                        end
                        else
                            mem_wdata = mark_word;
                    end
                end
            end
            md5de_pkg::ST_PAD:
            begin
                mem_we = 1'b1;
                if (need80_reg)
                begin
                    mem_wdata   = md5de_pkg::PAD_MARK;
                    need80_next = 1'b0;
                end
                else if ((pos_reg == md5de_pkg::LAST_POS) && lenlo_reg)
                begin
                    mem_wdata    = bit_len[63:32];
                    lendone_next = 1'b1;
                end
                else if (pos_reg == md5de_pkg::LEN_POS)
                begin
                    mem_wdata  = bit_len[31:0];
                    lenlo_next = 1'b1;
                end
                else
                    mem_wdata = 32'h0;
            end
            md5de_pkg::ST_ROUND:
            begin
                // Fetch the word for the following round
                mem_raddr    = md5de_pkg::msg_index(6'(rnd_reg + 6'd1));
                work_next[0] = work_reg[3];
                work_next[1] = b_new;
                work_next[2] = work_reg[1];
                work_next[3] = work_reg[2];
                rnd_next     = 6'(rnd_reg + 6'd1);
            end
            md5de_pkg::ST_ADD:
            begin
                for (int i = 0; i < 4; i++)
                    chain_next[i] = chain_reg[i] + work_reg[i];
            end
            md5de_pkg::ST_OUT:
            begin
                // Drop the finished message and restart from the initial values
                chain_next[0] = md5de_pkg::IV_A;
                chain_next[1] = md5de_pkg::IV_B;
                chain_next[2] = md5de_pkg::IV_C;
                chain_next[3] = md5de_pkg::IV_D;
                for (int i = 0; i < 4; i++)
                    work_next[i] = 32'h0;
                bytes_next   = '0;
                final_next   = 1'b0;
                need80_next  = 1'b0;
                lenlo_next   = 1'b0;
                lendone_next = 1'b0;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase

        if (mem_we)
            pos_next = 4'(pos_reg + 4'd1);

        // Load the working words as a block compression starts
        if (wrap)
        begin
            for (int i = 0; i < 4; i++)
                work_next[i] = chain_reg[i];
            rnd_next = 6'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            buf_mem[pos_reg] <= mem_wdata;
        rdata_reg <= buf_mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= md5de_pkg::ST_IDLE;
            pos_reg      <= 4'd0;
            bytes_reg    <= '0;
            rnd_reg      <= 6'd0;
            need80_reg   <= 1'b0;
            final_reg    <= 1'b0;
            lenlo_reg    <= 1'b0;
            lendone_reg  <= 1'b0;
            chain_reg[0] <= md5de_pkg::IV_A;
            chain_reg[1] <= md5de_pkg::IV_B;
            chain_reg[2] <= md5de_pkg::IV_C;
            chain_reg[3] <= md5de_pkg::IV_D;
            for (int i = 0; i < 4; i++)
                work_reg[i] <= 32'h0;
        end
        else
        begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            bytes_reg   <= bytes_next;
            rnd_reg     <= rnd_next;
            need80_reg  <= need80_next;
            final_reg   <= final_next;
            lenlo_reg   <= lenlo_next;
            lendone_reg <= lendone_next;
            for (int i = 0; i < 4; i++)
            begin
                chain_reg[i] <= chain_next[i];
                work_reg[i]  <= work_next[i];
            end
        end
    end

endmodule

`default_nettype wire
